// ----- rtl/clcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_pkg
// Shared types and constants of the two-line character display cursor
// sequencer: display geometry, controller command bytes, operation kinds.
// ----------------------------------------------------------------------------
package clcs_pkg;

	localparam int ROW_WIDTH   = 16;
	localparam int TOTAL_CHARS = 32;

	localparam int POS_W  = $clog2(TOTAL_CHARS + 1);
	// longest expansion: line one, ROW_WIDTH cursor rights, left, space, left
	localparam int STEP_W = $clog2(ROW_WIDTH + 4);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [7:0] CMD_CUR_LEFT  = 8'h10;
	localparam logic [7:0] CMD_CUR_RIGHT = 8'h14;
	localparam logic [7:0] CMD_LINE_ONE  = 8'h80;
	localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;
	localparam logic [7:0] SPACE_CODE    = 8'h20;

	typedef enum logic [2:0] {
		OP_CLEAR      = 3'd0,
		OP_PUT        = 3'd1,
		OP_PUT_LINE2  = 3'd2,
		OP_PUT_HOME   = 3'd3,
		OP_ERASE      = 3'd4,
		OP_ERASE_WRAP = 3'd5
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] code;
	} op_t;

endpackage

// ----- rtl/char_lcd_cursor_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer
// Turns characters and clear requests into controller command and data bytes
// for a two-line character display, tracking the cursor position.
//
// channel  dir  tdata            tuser        tlast
// s_*      in   [7:0] char_code  [0] action   -
// m_*      out  [7:0] byte_value [0] is_data  last
// cfg_*    in   cfg_wr_data = backspace code, written when cfg_wr_en
//
// One byte leaves per cycle unless the output stalls; an item yields 0 to
// ROW_WIDTH + 4 bytes, set by the back end's step counter.
// Input is taken whenever the 4-entry operation queue has room.
// Reset clears position, backspace code, queue and output register.
// A stalled output holds its byte; the back end waits, the front keeps filling.
// ----------------------------------------------------------------------------
module char_lcd_cursor_sequencer
	import clcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] byte_value
	output logic [0:0]  m_tuser,   // [0] is_data
	output logic        m_tlast
);

	logic push;
	op_t  push_op;
	logic q_full;
	logic pop;
	logic head_valid;
	op_t  head_op;

	clcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_action   (s_tuser[0]),
		.in_code     (s_tdata),
		.q_full      (q_full),
		.push        (push),
		.push_op     (push_op)
	);

	clcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	clcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_op     (head_op),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_is_data (m_tuser[0]),
		.out_byte    (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

// ----- rtl/clcs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_front
// Accepts input items, tracks the cursor position and turns each item into
// at most one operation for the back end. Holds the backspace code register.
// ----------------------------------------------------------------------------
module clcs_front
	import clcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_action,
	input  logic [7:0] in_code,
	input  logic       q_full,
	output logic       push,
	output op_t        push_op
);

	logic [7:0]       bs_code_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	logic             drop;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && !drop;

	always_comb begin
		push_op.kind = OP_PUT;
		push_op.code = in_code;
		pos_next     = pos_q + POS_W'(1);
		drop         = 1'b0;
		if (in_action) begin
			push_op.kind = OP_CLEAR;
			pos_next     = '0;
		end else if (in_code == bs_code_q) begin
			pos_next = pos_q - POS_W'(1);
			if (pos_q == '0) begin
				// nothing to erase: drop the item
				drop     = 1'b1;
				pos_next = pos_q;
			end else if (pos_q == POS_W'(ROW_WIDTH)) begin
				push_op.kind = OP_ERASE_WRAP;
			end else begin
				push_op.kind = OP_ERASE;
			end
		end else if (pos_q == POS_W'(ROW_WIDTH)) begin
			push_op.kind = OP_PUT_LINE2;
		end else if (pos_q >= POS_W'(TOTAL_CHARS)) begin
			push_op.kind = OP_PUT_HOME;
			pos_next     = POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_code_q <= '0;
			pos_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				bs_code_q <= cfg_wr_data;
			end
			if (accept) begin
				pos_q <= pos_next;
			end
		end
	end

endmodule

// ----- rtl/clcs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_queue
// Short operation queue between the front end and the back end.
// ----------------------------------------------------------------------------
module clcs_queue
	import clcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	op_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full operation queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty operation queue");

endmodule

// ----- rtl/clcs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_back
// Expands the operation at the queue head into controller bytes, one per
// cycle unless stalled, into an output register the downstream side drains.
// ----------------------------------------------------------------------------
module clcs_back
	import clcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  op_t        head_op,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_is_data,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam int WRAP_LEAD = ROW_WIDTH + 1;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_is_data_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              load;
	logic              gen_is_data;
	logic [7:0]        gen_byte;
	logic              gen_last;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && gen_last;
	assign out_valid = out_valid_q;
	assign out_is_data = out_is_data_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_comb begin
		logic [STEP_W-1:0] erase_idx;
		logic              in_erase;
		erase_idx   = step_q;
		in_erase    = 1'b0;
		gen_is_data = 1'b0;
		gen_byte    = CMD_CLEAR;
		gen_last    = 1'b1;
		case (head_op.kind)
			OP_CLEAR: begin
				gen_byte = CMD_CLEAR;
			end
			OP_PUT: begin
				gen_is_data = 1'b1;
				gen_byte    = head_op.code;
			end
			OP_PUT_LINE2, OP_PUT_HOME: begin
				if (step_q == '0) begin
					gen_byte = (head_op.kind == OP_PUT_LINE2) ? CMD_LINE_TWO : CMD_HOME;
					gen_last = 1'b0;
				end else begin
					gen_is_data = 1'b1;
					gen_byte    = head_op.code;
				end
			end
			OP_ERASE: begin
				in_erase = 1'b1;
			end
			OP_ERASE_WRAP: begin
				// walk the cursor to the end of line one, then erase
				gen_last = 1'b0;
				if (step_q == '0) begin
					gen_byte = CMD_LINE_ONE;
				end else if (step_q <= STEP_W'(ROW_WIDTH)) begin
					gen_byte = CMD_CUR_RIGHT;
				end else begin
					in_erase  = 1'b1;
					erase_idx = step_q - STEP_W'(WRAP_LEAD);
				end
			end
			default: begin
				gen_byte = CMD_CLEAR;
			end
		endcase
		if (in_erase) begin
			gen_last = 1'b0;
			if (erase_idx == STEP_W'(1)) begin
				gen_is_data = 1'b1;
				gen_byte    = SPACE_CODE;
			end else begin
				gen_is_data = 1'b0;
				gen_byte    = CMD_CUR_LEFT;
				gen_last    = (erase_idx == STEP_W'(2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_is_data_q <= gen_is_data;
			out_byte_q    <= gen_byte;
			out_last_q    <= gen_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				step_q <= gen_last ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	a_step_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) |-> head_valid)
		else $error("step counter running without an operation");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(ROW_WIDTH + 3))
		else $error("step counter past longest expansion");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == '0))
		else $error("step counter not cleared after last byte");

endmodule

// ----- sim/char_lcd_cursor_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer_tb
// Self-checking bench for the two-line display cursor sequencer. A short
// directed list walks the corner positions (empty line, end of line one,
// start of line two), then random character streams run under several
// backspace codes. Every accepted item is expanded by an in-bench model of
// the cursor logic into command and data bytes, and the output stream is
// compared byte by byte, with random bursts on the input and random stalls
// on the output.
// ----------------------------------------------------------------------------
module char_lcd_cursor_sequencer_tb;
	import clcs_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASE_ITEMS = 85;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic       is_data;
		logic [7:0] value;
		logic       last;
	} lcd_byte_t;

	typedef struct packed {
		logic                  act;
		logic [7:0]            code;
		logic [4:0]            reps;
		logic                  typed;
		logic [1:0]            n_typed;
		lcd_byte_t [0:2]       typed_b;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	localparam lcd_byte_t NO_BYTE    = '0;
	localparam lcd_byte_t CLEAR_LAST = '{1'b0, CMD_CLEAR, 1'b1};
	localparam lcd_byte_t LEFT_MID   = '{1'b0, CMD_CUR_LEFT, 1'b0};
	localparam lcd_byte_t LEFT_LAST  = '{1'b0, CMD_CUR_LEFT, 1'b1};
	localparam lcd_byte_t SPACE_MID  = '{1'b1, SPACE_CODE, 1'b0};

	localparam logic [7:0] BS_SETTINGS [4] = '{8'h08, 8'hFF, 8'h41, 8'h00};

	// backspace code is 0 after reset
	localparam int N_DIR_ROWS = 12;
	localparam stim_row_t DIR_ROWS [N_DIR_ROWS] = '{
		'{1'b0, 8'h00, 5'd1,  1'b1, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
		'{1'b1, 8'hFF, 5'd1,  1'b1, 2'd1, '{CLEAR_LAST, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h41, 5'd1,  1'b1, 2'd1, '{'{1'b1, 8'h41, 1'b1}, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'hFF, 5'd1,  1'b1, 2'd1, '{'{1'b1, 8'hFF, 1'b1}, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h00, 5'd1,  1'b1, 2'd3, '{LEFT_MID, SPACE_MID, LEFT_LAST}},
		'{1'b0, 8'h80, 5'd15, 1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h00, 5'd1,  1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h7E, 5'd1,  1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h01, 5'd1,  1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h00, 5'd1,  1'b0, 2'd0, '{NO_BYTE, NO_BYTE, NO_BYTE}},
		'{1'b1, 8'h00, 5'd1,  1'b1, 2'd1, '{CLEAR_LAST, NO_BYTE, NO_BYTE}},
		'{1'b0, 8'h20, 5'd1,  1'b1, 2'd1, '{'{1'b1, SPACE_CODE, 1'b1}, NO_BYTE, NO_BYTE}}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] char_code
	logic [0:0] s_tuser;   // [0] action
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] byte_value
	logic [0:0] m_tuser;   // [0] is_data
	logic       m_tlast;

	char_lcd_cursor_sequencer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	// cursor model state
	logic [POS_W-1:0] cursor_pos = '0;
	logic [7:0]       bs_code = 8'h00;

	lcd_byte_t item_bytes[$];
	lcd_byte_t lcd_bytes_due[$];
	lcd_byte_t want;

	int n_items = 0;
	int n_bytes = 0;
	int n_mismatch = 0;
	int n_home = 0;
	int n_line2 = 0;
	int n_erase_wrap = 0;
	int n_bs_settings = 1;
	int idle_cycles = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void expand_to_lcd_bytes(input logic act, input logic [7:0] code);
		item_bytes.delete();
		if (act) begin
			item_bytes.push_back('{1'b0, CMD_CLEAR, 1'b0});
			cursor_pos = '0;
		end else if (code == bs_code) begin
			// nothing to erase on an empty display
			if (cursor_pos != 0) begin
				if (cursor_pos == ROW_WIDTH) begin
					// step back to the end of line one before erasing
					item_bytes.push_back('{1'b0, CMD_LINE_ONE, 1'b0});
					for (int i = 0; i < ROW_WIDTH; i++)
						item_bytes.push_back('{1'b0, CMD_CUR_RIGHT, 1'b0});
					n_erase_wrap++;
				end
				item_bytes.push_back('{1'b0, CMD_CUR_LEFT, 1'b0});
				item_bytes.push_back('{1'b1, SPACE_CODE, 1'b0});
				item_bytes.push_back('{1'b0, CMD_CUR_LEFT, 1'b0});
				cursor_pos = cursor_pos - 1'b1;
			end
		end else begin
			if (cursor_pos == ROW_WIDTH) begin
				item_bytes.push_back('{1'b0, CMD_LINE_TWO, 1'b0});
				n_line2++;
			end else if (cursor_pos >= TOTAL_CHARS) begin
				cursor_pos = '0;
				item_bytes.push_back('{1'b0, CMD_HOME, 1'b0});
				n_home++;
			end
			item_bytes.push_back('{1'b1, code, 1'b0});
			cursor_pos = cursor_pos + 1'b1;
		end
		if (item_bytes.size() != 0)
			item_bytes[item_bytes.size() - 1].last = 1'b1;
	endfunction

	// present one item, hold it until taken, then queue its bytes
	task automatic send_item(input stim_row_t row);
		s_tvalid <= 1'b1;
		s_tuser  <= row.act;
		s_tdata  <= row.code;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_items++;
		expand_to_lcd_bytes(row.act, row.code);
		if (row.typed) begin
			for (int i = 0; i < row.n_typed; i++)
				lcd_bytes_due.push_back(row.typed_b[i]);
		end else begin
			foreach (item_bytes[i])
				lcd_bytes_due.push_back(item_bytes[i]);
		end
	endtask

	// wait out every byte plus any zero-byte items still in flight, then write
	task automatic write_backspace_code(input logic [7:0] value);
		s_tvalid <= 1'b0;
		while (lcd_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		bs_code = value;
		n_bs_settings++;
	endtask

	task automatic note_mismatch(input string what);
		n_mismatch++;
		if (n_mismatch <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_bytes++;
			if (lcd_bytes_due.size() == 0) begin
				note_mismatch($sformatf("unexpected byte is_data=%0b value=%02h last=%0b",
					m_tuser[0], m_tdata, m_tlast));
			end else begin
				want = lcd_bytes_due.pop_front();
				if (m_tuser[0] !== want.is_data || m_tdata !== want.value ||
						m_tlast !== want.last)
					note_mismatch($sformatf(
						"exp is_data=%0b value=%02h last=%0b, got is_data=%0b value=%02h last=%0b",
						want.is_data, want.value, want.last, m_tuser[0], m_tdata, m_tlast));
			end
		end
	end

	// output back-pressure, switching between patterns
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(3));
			rx_left <= $urandom_range(250, 40);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_RANDOM:   m_tready <= ($urandom_range(9) < 7);
			RX_PERIODIC: m_tready <= ((rx_tick % 8) < 5);
			default:     m_tready <= ($urandom_range(3) == 0);
		endcase
	end

	// count cycles with work pending but no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(!s_tvalid && lcd_bytes_due.size() == 0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
					STALL_LIMIT, lcd_bytes_due.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t row;
		int        burst_left;
		int        gap;
		int        pick;
		int        bs_share;
		logic [7:0] phase_code;

		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'h00;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tuser     = 1'b0;
		m_tready    = 1'b0;
		burst_left  = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[r]) begin
			for (int k = 0; k < DIR_ROWS[r].reps; k++)
				send_item(DIR_ROWS[r]);
		end

		for (int ph = 0; ph <= 4; ph++) begin
			phase_code = (ph < 4) ? BS_SETTINGS[ph] : 8'($urandom_range(255));
			write_backspace_code(phase_code);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(24, 1);
					gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
					if (gap != 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;

				// dwell near the line boundary and the last position
				bs_share = ((cursor_pos >= ROW_WIDTH - 2 && cursor_pos <= ROW_WIDTH + 2) ||
					cursor_pos >= TOTAL_CHARS - 2) ? 45 : 12;
				pick = $urandom_range(99);
				row = '0;
				row.reps = 5'd1;
				if (pick < 2) begin
					row.act  = 1'b1;
					row.code = 8'($urandom_range(255));
				end else if (pick < bs_share) begin
					row.code = bs_code;
				end else begin
					row.code = 8'($urandom_range(255));
				end
				send_item(row);
			end
		end
		s_tvalid <= 1'b0;

		while (lcd_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items and %0d display bytes under %0d backspace codes",
			n_items, n_bytes, n_bs_settings);
		$display("line two entries %0d, home wraps %0d, erases across the line break %0d",
			n_line2, n_home, n_erase_wrap);
		if (n_mismatch == 0 && lcd_bytes_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d bytes never seen", n_mismatch, lcd_bytes_due.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/clcs_pkg.sv
rtl/clcs_front.sv
rtl/clcs_queue.sv
rtl/clcs_back.sv
rtl/char_lcd_cursor_sequencer.sv
sim/char_lcd_cursor_sequencer_tb.sv
